// ----- rtl/core/gtt_pkg.sv -----
// Shared types, widths and constants of the gate travel tracker.
package gtt_pkg;

    // Field widths fixed by the item and register formats.
    localparam int NOW_W      = 32;
    localparam int SETTLE_W   = 16;
    localparam int COOL_W     = 16;
    localparam int TRAVEL_W   = 20;
    localparam int EST_W      = TRAVEL_W + 1;
    localparam int REM_W      = 21;
    localparam int PROD_W     = 2 * TRAVEL_W;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 3;

    // Behavioural constants.
    localparam int FLIP_WINDOW   = 4000;
    localparam int FLIP_CONFIRM  = 3;
    localparam int REVERSE_EXTRA = 3000;
    localparam logic [TRAVEL_W-1:0] REM_MAX = '1;

    // Register reset values.
    localparam logic [SETTLE_W-1:0] SETTLE_RST      = 16'd1500;
    localparam logic [TRAVEL_W-1:0] OPEN_TRAVEL_RST  = 20'd20000;
    localparam logic [TRAVEL_W-1:0] CLOSE_TRAVEL_RST = 20'd20000;
    localparam logic [COOL_W-1:0]   COOLDOWN_RST     = 16'd1000;
    localparam logic                OPEN_IS_LOW_RST  = 1'b1;

    typedef enum logic [1:0]
    {
        ACT_SAMPLE  = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_TAKE    = 2'd2,
        ACT_BOOT    = 2'd3
    } action_t;

    typedef enum logic [1:0]
    {
        MOT_IDLE    = 2'd0,
        MOT_OPENING = 2'd1,
        MOT_CLOSING = 2'd2,
        MOT_UNKNOWN = 2'd3
    } motion_t;

    typedef enum logic [1:0]
    {
        EV_NONE    = 2'd0,
        EV_OPENING = 2'd1,
        EV_CLOSING = 2'd2
    } event_t;

    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_SETTLE       = 3'd0,
        REG_OPEN_TRAVEL  = 3'd1,
        REG_CLOSE_TRAVEL = 3'd2,
        REG_COOLDOWN     = 3'd3,
        REG_OPEN_IS_LOW  = 3'd4
    } reg_idx_t;

    typedef struct packed
    {
        logic [SETTLE_W-1:0] settle_ms;
        logic [TRAVEL_W-1:0] open_travel_ms;
        logic [TRAVEL_W-1:0] close_travel_ms;
        logic [COOL_W-1:0]   cooldown_ms;
        logic                open_is_low;
    } cfg_t;

    typedef struct packed
    {
        logic capture;
        logic exec;
        logic check;
        logic mul;
        logic div_start;
        logic commit;
        logic report;
    } dp_cmd_t;

    typedef struct packed
    {
        logic act_sample;
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/gtt_if.sv -----
// Request and result channel interfaces of the gate travel tracker.
interface gtt_in_if
    import gtt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [NOW_W-1:0] now_ms;
    logic             pin_level;

    modport source (output valid, action, now_ms, pin_level, input ready);
    modport sink (input valid, action, now_ms, pin_level, output ready);
endinterface

interface gtt_out_if
    import gtt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic                    settled_open;
    logic                    partial;
    logic [1:0]              move_state;
    logic signed [REM_W-1:0] remaining_ms;
    logic [1:0]              external_event;
    logic [NOW_W-1:0]        since_trigger_ms;

    modport source (output valid, accepted, settled_open, partial, move_state, remaining_ms,
                    external_event, since_trigger_ms, input ready);
    modport sink (input valid, accepted, settled_open, partial, move_state, remaining_ms,
                  external_event, since_trigger_ms, output ready);
endinterface

// ----- rtl/core/gtt_cfg.sv -----
// APB configuration register bank of the gate travel tracker.
module gtt_cfg
    import gtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic [TRAVEL_W-1:0] open_travel_reg, open_travel_next;
    logic [TRAVEL_W-1:0] close_travel_reg, close_travel_next;
    logic [COOL_W-1:0]   cooldown_reg, cooldown_next;
    logic                open_is_low_reg, open_is_low_next;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        settle_next       = settle_reg;
        open_travel_next  = open_travel_reg;
        close_travel_next = close_travel_reg;
        cooldown_next     = cooldown_reg;
        open_is_low_next  = open_is_low_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SETTLE:       settle_next       = pwdata[SETTLE_W-1:0];
                REG_OPEN_TRAVEL:  open_travel_next  = pwdata[TRAVEL_W-1:0];
                REG_CLOSE_TRAVEL: close_travel_next = pwdata[TRAVEL_W-1:0];
                REG_COOLDOWN:     cooldown_next     = pwdata[COOL_W-1:0];
                REG_OPEN_IS_LOW:  open_is_low_next  = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg       <= SETTLE_RST;
            open_travel_reg  <= OPEN_TRAVEL_RST;
            close_travel_reg <= CLOSE_TRAVEL_RST;
            cooldown_reg     <= COOLDOWN_RST;
            open_is_low_reg  <= OPEN_IS_LOW_RST;
        end
        else
        begin
            settle_reg       <= settle_next;
            open_travel_reg  <= open_travel_next;
            close_travel_reg <= close_travel_next;
            cooldown_reg     <= cooldown_next;
            open_is_low_reg  <= open_is_low_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_SETTLE:       prdata = DATA_W'(settle_reg);
            REG_OPEN_TRAVEL:  prdata = DATA_W'(open_travel_reg);
            REG_CLOSE_TRAVEL: prdata = DATA_W'(close_travel_reg);
            REG_COOLDOWN:     prdata = DATA_W'(cooldown_reg);
            REG_OPEN_IS_LOW:  prdata = DATA_W'(open_is_low_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.settle_ms       = settle_reg;
    assign cfg.open_travel_ms  = open_travel_reg;
    assign cfg.close_travel_ms = close_travel_reg;
    assign cfg.cooldown_ms     = cooldown_reg;
    assign cfg.open_is_low     = open_is_low_reg;

endmodule

// ----- rtl/core/gtt_div.sv -----
// Restoring divider, one quotient bit per cycle, for the reversal estimate.
module gtt_div
    import gtt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [TRAVEL_W-1:0] divisor,
    output logic [TRAVEL_W-1:0] quotient,
    output logic                done
);

    localparam int STEPS = TRAVEL_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [TRAVEL_W-1:0] rem_reg, rem_next;
    logic [TRAVEL_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [TRAVEL_W:0]   trial;
    logic [TRAVEL_W:0]   diff;

    // The caller guarantees the upper half of the dividend is below the divisor,
    // so the quotient fits in TRAVEL_W bits.
    assign trial = {rem_reg, quo_reg[TRAVEL_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = dividend[PROD_W-1:TRAVEL_W];
            quo_next  = dividend[TRAVEL_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[TRAVEL_W])
            begin
                rem_next = diff[TRAVEL_W-1:0];
                quo_next = {quo_reg[TRAVEL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TRAVEL_W-1:0];
                quo_next = {quo_reg[TRAVEL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/core/gtt_dp.sv -----
// Datapath of the gate travel tracker: tracking state, update logic and result register.
module gtt_dp
    import gtt_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic [1:0]              in_action,
    input  logic [NOW_W-1:0]        in_now_ms,
    input  logic                    in_pin_level,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_accepted,
    output logic                    out_settled_open,
    output logic                    out_partial,
    output logic [1:0]              out_move_state,
    output logic signed [REM_W-1:0] out_remaining_ms,
    output logic [1:0]              out_external_event,
    output logic [NOW_W-1:0]        out_since_trigger_ms
);

    localparam int TW = TIME_WIDTH;
    localparam int CW = (TW > REM_W) ? TW : REM_W;
    localparam int SW = (TW > TRAVEL_W) ? TW : TRAVEL_W;

    // Tracking state.
    logic          stable_open_reg, stable_open_next;
    logic          previous_raw_reg, previous_raw_next;
    logic [TW-1:0] raw_change_reg, raw_change_next;
    logic [TW-1:0] deadline_reg, deadline_next;
    motion_t       motion_reg, motion_next;
    logic [TW-1:0] motion_start_reg, motion_start_next;
    logic          stop_pending_reg, stop_pending_next;
    logic          stopped_midway_reg, stopped_midway_next;
    logic [1:0]    flip_tally_reg, flip_tally_next;
    logic [TW-1:0] window_start_reg, window_start_next;
    event_t        pending_event_reg, pending_event_next;
    logic [TW-1:0] trigger_time_reg, trigger_time_next;
    logic          ever_pressed_reg, ever_pressed_next;

    // Per-request working registers.
    action_t             act_reg, act_next;
    logic [TW-1:0]       now_reg, now_next;
    logic                raw_reg, raw_next;
    logic                accepted_reg, accepted_next;
    event_t              event_reg, event_next;
    logic                need_div_reg, need_div_next;
    logic [TRAVEL_W-1:0] elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic                    res_accepted_reg, res_accepted_next;
    logic                    res_open_reg, res_open_next;
    logic                    res_partial_reg, res_partial_next;
    motion_t                 res_move_reg, res_move_next;
    logic signed [REM_W-1:0] res_remaining_reg, res_remaining_next;
    event_t                  res_event_reg, res_event_next;
    logic [NOW_W-1:0]        res_since_reg, res_since_next;

    logic [TW-1:0]       d_now_rct, d_dl_now, d_now_ws, d_now_dl, d_now_trig, d_elapsed;
    logic [CW-1:0]       d_dl_ext, elapsed_ext;
    logic                unsettled, settle_done, dl_ahead, rem_neg, deadline_past;
    logic                window_over, flip_confirm, cool_block, elapsed_full;
    logic [1:0]          tally_inc;
    logic [TRAVEL_W-1:0] travel_sel, rem_clamp, quotient, est;
    logic [EST_W-1:0]    est_sum;
    logic [SW-1:0]       ws_sum, now_sum, open_sum, est_dl_sum;
    logic signed [REM_W-1:0] remaining_val;
    motion_t             move_code;
    logic                div_done;

    // Wrap-safe differences.
    assign d_now_rct  = now_reg - raw_change_reg;
    assign d_dl_now   = deadline_reg - now_reg;
    assign d_now_ws   = now_reg - window_start_reg;
    assign d_now_dl   = now_reg - deadline_reg;
    assign d_now_trig = now_reg - trigger_time_reg;
    assign d_elapsed  = now_reg - motion_start_reg;
    assign d_dl_ext    = CW'(d_dl_now);
    assign elapsed_ext = CW'(d_elapsed);

    assign unsettled   = (previous_raw_reg != stable_open_reg)
                      && (CW'(d_now_rct) < CW'(cfg.settle_ms));
    assign settle_done = CW'(d_now_rct) >= CW'(cfg.settle_ms);

    assign dl_ahead  = (motion_reg != MOT_IDLE) && (d_dl_now != '0) && !d_dl_now[TW-1];
    assign rem_neg   = !dl_ahead && !unsettled;
    assign rem_clamp = (d_dl_ext > CW'(REM_MAX)) ? REM_MAX : d_dl_ext[TRAVEL_W-1:0];
    assign remaining_val = dl_ahead  ? $signed({1'b0, rem_clamp}) :
                           unsettled ? '0 : '1;
    assign move_code = rem_neg ? MOT_IDLE :
                       (motion_reg == MOT_IDLE) ? MOT_UNKNOWN : motion_reg;
    assign deadline_past = !d_now_dl[TW-1];

    assign window_over  = CW'(d_now_ws) > CW'(FLIP_WINDOW);
    assign tally_inc    = (flip_tally_reg == 2'(FLIP_CONFIRM)) ? flip_tally_reg
                                                               : flip_tally_reg + 2'd1;
    assign flip_confirm = (tally_inc >= 2'(FLIP_CONFIRM)) && (motion_reg == MOT_IDLE);

    assign cool_block   = ever_pressed_reg && (CW'(d_now_trig) < CW'(cfg.cooldown_ms));
    assign elapsed_full = elapsed_ext >= CW'(cfg.close_travel_ms);

    assign travel_sel = stable_open_reg ? cfg.close_travel_ms : cfg.open_travel_ms;
    assign ws_sum     = SW'(window_start_reg) + SW'(travel_sel);
    assign now_sum    = SW'(now_reg) + SW'(travel_sel);
    assign open_sum   = SW'(now_reg) + SW'(cfg.open_travel_ms);

    // Reversal estimate: scaled elapsed time plus margin, capped at full opening travel.
    assign est_sum    = EST_W'(quotient) + EST_W'(REVERSE_EXTRA);
    assign est        = (est_sum > EST_W'(cfg.open_travel_ms)) ? cfg.open_travel_ms
                                                                : est_sum[TRAVEL_W-1:0];
    assign est_dl_sum = SW'(now_reg) + SW'(est);

    gtt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (cfg.close_travel_ms),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        stable_open_next    = stable_open_reg;
        previous_raw_next   = previous_raw_reg;
        raw_change_next     = raw_change_reg;
        deadline_next       = deadline_reg;
        motion_next         = motion_reg;
        motion_start_next   = motion_start_reg;
        stop_pending_next   = stop_pending_reg;
        stopped_midway_next = stopped_midway_reg;
        flip_tally_next     = flip_tally_reg;
        window_start_next   = window_start_reg;
        pending_event_next  = pending_event_reg;
        trigger_time_next   = trigger_time_reg;
        ever_pressed_next   = ever_pressed_reg;
        act_next            = act_reg;
        now_next            = now_reg;
        raw_next            = raw_reg;
        accepted_next       = accepted_reg;
        event_next          = event_reg;
        need_div_next       = need_div_reg;
        elapsed_next        = elapsed_reg;
        prod_next           = prod_reg;

        if (cmd.capture)
        begin
            act_next = action_t'(in_action);
            now_next = TW'(in_now_ms);
            raw_next = cfg.open_is_low ? !in_pin_level : in_pin_level;
        end

        if (cmd.exec)
        begin
            accepted_next = 1'b0;
            event_next    = EV_NONE;
            need_div_next = 1'b0;
            case (act_reg)
                ACT_SAMPLE:
                begin
                    if (raw_reg != previous_raw_reg)
                    begin
                        previous_raw_next = raw_reg;
                        raw_change_next   = now_reg;
                        if (window_over)
                        begin
                            window_start_next = now_reg;
                            flip_tally_next   = 2'd1;
                        end
                        else
                        begin
                            flip_tally_next = tally_inc;
                            // Enough flips inside the window while idle: someone else moved the gate.
                            if (flip_confirm)
                            begin
                                motion_next        = stable_open_reg ? MOT_CLOSING
                                                                     : MOT_OPENING;
                                motion_start_next  = window_start_reg;
                                deadline_next      = ws_sum[TW-1:0];
                                pending_event_next = stable_open_reg ? EV_CLOSING
                                                                     : EV_OPENING;
                            end
                        end
                    end
                    else if ((raw_reg != stable_open_reg) && settle_done)
                    begin
                        stable_open_next    = raw_reg;
                        stopped_midway_next = raw_reg && stop_pending_reg;
                        stop_pending_next   = 1'b0;
                        deadline_next       = '0;
                        motion_next         = MOT_IDLE;
                    end
                end
                ACT_TRIGGER:
                begin
                    if (!cool_block)
                    begin
                        ever_pressed_next = 1'b1;
                        trigger_time_next = now_reg;
                        accepted_next     = 1'b1;
                        if (rem_neg)
                        begin
                            motion_next       = stable_open_reg ? MOT_CLOSING : MOT_OPENING;
                            motion_start_next = now_reg;
                            deadline_next     = now_sum[TW-1:0];
                            stop_pending_next = 1'b0;
                        end
                        else if (motion_reg == MOT_CLOSING)
                        begin
                            if (elapsed_full)
                            begin
                                motion_next       = MOT_OPENING;
                                motion_start_next = now_reg;
                                deadline_next     = open_sum[TW-1:0];
                                stop_pending_next = 1'b0;
                            end
                            else
                            begin
                                need_div_next = 1'b1;
                                elapsed_next  = elapsed_ext[TRAVEL_W-1:0];
                            end
                        end
                        else
                        begin
                            motion_next       = MOT_UNKNOWN;
                            deadline_next     = now_reg;
                            stop_pending_next = 1'b1;
                        end
                    end
                end
                ACT_TAKE:
                begin
                    event_next         = pending_event_reg;
                    pending_event_next = EV_NONE;
                end
                ACT_BOOT:
                begin
                    stable_open_next  = raw_reg;
                    previous_raw_next = raw_reg;
                end
                default: ;
            endcase
        end

        // Second half of a status sample: end travel once the deadline has passed quietly.
        if (cmd.check)
        begin
            if ((motion_reg != MOT_IDLE) && deadline_past && !unsettled)
            begin
                motion_next       = MOT_IDLE;
                stop_pending_next = 1'b0;
            end
        end

        if (cmd.mul)
        begin
            prod_next = PROD_W'(elapsed_reg) * PROD_W'(cfg.open_travel_ms);
        end

        if (cmd.commit)
        begin
            motion_next       = MOT_OPENING;
            motion_start_next = now_reg;
            deadline_next     = est_dl_sum[TW-1:0];
            stop_pending_next = 1'b0;
            need_div_next     = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next     = out_valid_reg;
        res_accepted_next  = res_accepted_reg;
        res_open_next      = res_open_reg;
        res_partial_next   = res_partial_reg;
        res_move_next      = res_move_reg;
        res_remaining_next = res_remaining_reg;
        res_event_next     = res_event_reg;
        res_since_next     = res_since_reg;
        if (cmd.report)
        begin
            out_valid_next     = 1'b1;
            res_accepted_next  = accepted_reg;
            res_open_next      = stable_open_reg;
            res_partial_next   = stable_open_reg && stopped_midway_reg;
            res_move_next      = move_code;
            res_remaining_next = remaining_val;
            res_event_next     = event_reg;
            res_since_next     = NOW_W'(d_now_trig);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_open_reg    <= 1'b0;
            previous_raw_reg   <= 1'b0;
            raw_change_reg     <= '0;
            deadline_reg       <= '0;
            motion_reg         <= MOT_IDLE;
            motion_start_reg   <= '0;
            stop_pending_reg   <= 1'b0;
            stopped_midway_reg <= 1'b0;
            flip_tally_reg     <= '0;
            window_start_reg   <= '0;
            pending_event_reg  <= EV_NONE;
            trigger_time_reg   <= '0;
            ever_pressed_reg   <= 1'b0;
            accepted_reg       <= 1'b0;
            event_reg          <= EV_NONE;
            need_div_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            stable_open_reg    <= stable_open_next;
            previous_raw_reg   <= previous_raw_next;
            raw_change_reg     <= raw_change_next;
            deadline_reg       <= deadline_next;
            motion_reg         <= motion_next;
            motion_start_reg   <= motion_start_next;
            stop_pending_reg   <= stop_pending_next;
            stopped_midway_reg <= stopped_midway_next;
            flip_tally_reg     <= flip_tally_next;
            window_start_reg   <= window_start_next;
            pending_event_reg  <= pending_event_next;
            trigger_time_reg   <= trigger_time_next;
            ever_pressed_reg   <= ever_pressed_next;
            accepted_reg       <= accepted_next;
            event_reg          <= event_next;
            need_div_reg       <= need_div_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg           <= act_next;
        now_reg           <= now_next;
        raw_reg           <= raw_next;
        elapsed_reg       <= elapsed_next;
        prod_reg          <= prod_next;
        res_accepted_reg  <= res_accepted_next;
        res_open_reg      <= res_open_next;
        res_partial_reg   <= res_partial_next;
        res_move_reg      <= res_move_next;
        res_remaining_reg <= res_remaining_next;
        res_event_reg     <= res_event_next;
        res_since_reg     <= res_since_next;
    end

    assign stat.act_sample = (act_reg == ACT_SAMPLE);
    assign stat.need_div   = need_div_reg;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid            = out_valid_reg;
    assign out_accepted         = res_accepted_reg;
    assign out_settled_open     = res_open_reg;
    assign out_partial          = res_partial_reg;
    assign out_move_state       = res_move_reg;
    assign out_remaining_ms     = res_remaining_reg;
    assign out_external_event   = res_event_reg;
    assign out_since_trigger_ms = res_since_reg;

endmodule

// ----- rtl/core/gtt_ctrl.sv -----
// Sequencing state machine of the gate travel tracker.
module gtt_ctrl
    import gtt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_COMMIT,
        S_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   take;

    assign take = in_valid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:   state_next = stat.act_sample ? S_CHECK : S_MUL;
            S_CHECK:  state_next = S_REPORT;
            // The product is formed for every request that is not a sample; it is only used when a division is due.
            S_MUL:    state_next = stat.need_div ? S_DSTART : S_REPORT;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: state_next = S_REPORT;
            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready      = ready_reg;
    assign cmd.capture   = take;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.check     = (state_reg == S_CHECK);
    assign cmd.mul       = (state_reg == S_MUL);
    assign cmd.div_start = (state_reg == S_DSTART);
    assign cmd.commit    = (state_reg == S_COMMIT);
    assign cmd.report    = (state_reg == S_REPORT) && stat.out_free;

endmodule

// ----- rtl/core/gate_travel_tracker_top.sv -----
// Top level of the gate travel tracker.
//
//   Channel   Direction  Handshake            Carries
//   in_ch     in         valid/ready          action, now_ms, pin_level
//   out_ch    out        valid/ready          one result per request
//   APB       in/out     psel/penable/pready  five configuration registers
//
// One request at a time. A request passes through EXEC, then CHECK for a sample
// or MUL otherwise, then REPORT; a reversing trigger adds DSTART, DWAIT and
// COMMIT, waiting on the 20-step divider that scales the elapsed closing time.
// The result register lets a new request in while the previous result waits.
// rst_n is asynchronous and active low; registers come up at their reset values.
module gate_travel_tracker_top
    import gtt_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    gtt_in_if.sink            in_ch,
    gtt_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    gtt_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gtt_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .cmd                  (cmd),
        .stat                 (stat),
        .in_action            (in_ch.action),
        .in_now_ms            (in_ch.now_ms),
        .in_pin_level         (in_ch.pin_level),
        .out_valid            (out_ch.valid),
        .out_ready            (out_ch.ready),
        .out_accepted         (out_ch.accepted),
        .out_settled_open     (out_ch.settled_open),
        .out_partial          (out_ch.partial),
        .out_move_state       (out_ch.move_state),
        .out_remaining_ms     (out_ch.remaining_ms),
        .out_external_event   (out_ch.external_event),
        .out_since_trigger_ms (out_ch.since_trigger_ms)
    );

    assign in_ch.ready = in_ready;

endmodule

// ----- rtl/core/gtt_chk.sv -----
// Port-level checker of the gate travel tracker and its bind to the top level.
module gtt_chk
    import gtt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    settled_open,
    input logic                    partial,
    input logic [1:0]              move_state,
    input logic signed [REM_W-1:0] remaining_ms,
    input logic [NOW_W-1:0]        since_trigger_ms
);

    // Only one request is in flight, so ready must drop straight after an acceptance.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is still being processed");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(remaining_ms)
            && $stable(move_state) && $stable(since_trigger_ms))
        else $error("stalled result changed");

    // An idle code and a remaining time of minus one always come together.
    a_idle_coherent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((move_state == MOT_IDLE) == (remaining_ms == '1)))
        else $error("move state and remaining time disagree on idle");

    a_partial_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && partial |-> settled_open)
        else $error("partial reported while the gate is not settled open");

endmodule

bind gate_travel_tracker_top gtt_chk u_gtt_chk
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .settled_open     (out_ch.settled_open),
    .partial          (out_ch.partial),
    .move_state       (out_ch.move_state),
    .remaining_ms     (out_ch.remaining_ms),
    .since_trigger_ms (out_ch.since_trigger_ms)
);

// ----- dv/tb_gate_travel_tracker_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the gate travel tracker: directed and random requests.
module tb_gate_travel_tracker_top;
    import gtt_pkg::*;

    localparam int QUIET_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 325;

    typedef struct packed
    {
        logic                    accepted;
        logic                    settled_open;
        logic                    partial;
        logic [1:0]              move_state;
        logic signed [REM_W-1:0] remaining_ms;
        logic [1:0]              external_event;
        logic [NOW_W-1:0]        since_trigger_ms;
    } gate_report_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    gtt_in_if  in_ch();
    gtt_out_if out_ch();

    gate_travel_tracker_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tracker copy kept by the testbench.
    cfg_t             cfg;
    logic             gate_open;
    logic             last_raw;
    logic             stop_armed;
    logic             halted_midway;
    logic             pressed_once;
    logic [1:0]       flip_count;
    motion_t          travel;
    event_t           held_event;
    logic [NOW_W-1:0] raw_flip_ms;
    logic [NOW_W-1:0] due_ms;
    logic [NOW_W-1:0] travel_start_ms;
    logic [NOW_W-1:0] window_ms;
    logic [NOW_W-1:0] press_ms;

    gate_report_t     pending_reports[$];
    gate_report_t     oldest;
    logic [NOW_W-1:0] clock_ms;
    logic             pin_now;
    bit               calm;
    int               hold_left;
    int               items_sent;
    int               mismatches;
    int               cycle_count;

    function automatic void reset_tracker();
        cfg.settle_ms       = SETTLE_RST;
        cfg.open_travel_ms  = OPEN_TRAVEL_RST;
        cfg.close_travel_ms = CLOSE_TRAVEL_RST;
        cfg.cooldown_ms     = COOLDOWN_RST;
        cfg.open_is_low     = OPEN_IS_LOW_RST;
        gate_open       = 1'b0;
        last_raw        = 1'b0;
        stop_armed      = 1'b0;
        halted_midway   = 1'b0;
        pressed_once    = 1'b0;
        flip_count      = '0;
        travel          = MOT_IDLE;
        held_event      = EV_NONE;
        raw_flip_ms     = '0;
        due_ms          = '0;
        travel_start_ms = '0;
        window_ms       = '0;
        press_ms        = '0;
    endfunction

    function automatic logic line_unsettled(logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] held;
        held = now - raw_flip_ms;
        return (last_raw != gate_open) && (held < cfg.settle_ms);
    endfunction

    // Travel time left: the time to a deadline ahead; else 0 while the line is unsettled, -1 when settled.
    function automatic longint time_left(logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] ahead;
        if (travel != MOT_IDLE)
        begin
            ahead = due_ms - now;
            if (ahead != 0 && !ahead[NOW_W-1])
                return (ahead > REM_MAX) ? longint'(REM_MAX) : longint'(ahead);
        end
        if (line_unsettled(now))
            return 0;
        return -1;
    endfunction

    function automatic void take_level(logic [NOW_W-1:0] now, logic raw);
        logic [NOW_W-1:0] lag;
        logic [NOW_W-1:0] span;
        if (raw != last_raw)
        begin
            last_raw    = raw;
            raw_flip_ms = now;
            span        = now - window_ms;
            if (span > FLIP_WINDOW)
            begin
                window_ms  = now;
                flip_count = 2'd1;
            end
            else
            begin
                if (flip_count < FLIP_CONFIRM)
                    flip_count++;
                // Enough flips while idle: someone else has moved the gate.
                if (flip_count >= FLIP_CONFIRM && travel == MOT_IDLE)
                begin
                    travel          = gate_open ? MOT_CLOSING : MOT_OPENING;
                    travel_start_ms = window_ms;
                    due_ms          = window_ms + (gate_open ? cfg.close_travel_ms
                                                             : cfg.open_travel_ms);
                    held_event      = gate_open ? EV_CLOSING : EV_OPENING;
                end
            end
        end
        else if (raw != gate_open && (now - raw_flip_ms) >= cfg.settle_ms)
        begin
            gate_open     = raw;
            halted_midway = raw && stop_armed;
            stop_armed    = 1'b0;
            due_ms        = '0;
            travel        = MOT_IDLE;
        end
        lag = now - due_ms;
        if (travel != MOT_IDLE && !lag[NOW_W-1] && !line_unsettled(now))
        begin
            travel     = MOT_IDLE;
            stop_armed = 1'b0;
        end
    endfunction

    function automatic logic try_trigger(logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] elapsed;
        logic [63:0]      est;
        if (pressed_once && (now - press_ms) < cfg.cooldown_ms)
            return 1'b0;
        pressed_once = 1'b1;
        press_ms     = now;
        if (time_left(now) < 0)
        begin
            travel          = gate_open ? MOT_CLOSING : MOT_OPENING;
            travel_start_ms = now;
            due_ms          = now + (gate_open ? cfg.close_travel_ms : cfg.open_travel_ms);
            stop_armed      = 1'b0;
        end
        else if (travel == MOT_CLOSING)
        begin
            // Reverse: scale the closing time done so far onto the opening travel.
            elapsed = now - travel_start_ms;
            if (elapsed >= cfg.close_travel_ms)
                est = 64'(cfg.open_travel_ms);
            else
                est = 64'(elapsed) * cfg.open_travel_ms / cfg.close_travel_ms + REVERSE_EXTRA;
            if (est > cfg.open_travel_ms)
                est = 64'(cfg.open_travel_ms);
            travel          = MOT_OPENING;
            travel_start_ms = now;
            due_ms          = now + est[NOW_W-1:0];
            stop_armed      = 1'b0;
        end
        else
        begin
            travel     = MOT_UNKNOWN;
            due_ms     = now;
            stop_armed = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic gate_report_t next_gate_report(action_t act, logic [NOW_W-1:0] now,
                                                      logic pin);
        gate_report_t rep;
        logic         raw;
        longint       left;
        rep = '0;
        raw = cfg.open_is_low ? !pin : pin;
        case (act)
            ACT_SAMPLE:  take_level(now, raw);
            ACT_TRIGGER: rep.accepted = try_trigger(now);
            ACT_TAKE:
            begin
                rep.external_event = held_event;
                held_event         = EV_NONE;
            end
            default:
            begin
                gate_open = raw;
                last_raw  = raw;
            end
        endcase
        left = time_left(now);
        if (left < 0)
            rep.move_state = MOT_IDLE;
        else if (travel == MOT_OPENING || travel == MOT_CLOSING)
            rep.move_state = travel;
        else
            rep.move_state = MOT_UNKNOWN;
        rep.settled_open     = gate_open;
        rep.partial          = gate_open && halted_midway;
        rep.remaining_ms     = left[REM_W-1:0];
        rep.since_trigger_ms = now - press_ms;
        return rep;
    endfunction

    function automatic void compare_field(string name, logic signed [63:0] want,
                                          logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int pause_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(action_t act, logic pin);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.now_ms    <= clock_ms;
        in_ch.pin_level <= pin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_reports.push_back(next_gate_report(act, clock_ms, pin));
        items_sent++;
        gap = pause_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_at(action_t act, logic [NOW_W-1:0] t, logic pin);
        clock_ms = t;
        send_request(act, pin);
    endtask

    task automatic wait_for_quiet();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SETTLE:       cfg.settle_ms       = value[SETTLE_W-1:0];
            REG_OPEN_TRAVEL:  cfg.open_travel_ms  = value[TRAVEL_W-1:0];
            REG_CLOSE_TRAVEL: cfg.close_travel_ms = value[TRAVEL_W-1:0];
            REG_COOLDOWN:     cfg.cooldown_ms     = value[COOL_W-1:0];
            REG_OPEN_IS_LOW:  cfg.open_is_low     = value[0];
            default:          ;
        endcase
    endtask

    // Reset settings: start, blink, stop mid-travel, external move, reversal, quiet deadline.
    task automatic test_default_registers();
        logic [NOW_W-1:0] t0;
        t0 = 32'hFFFF_F000;
        send_at(ACT_BOOT,    t0,         1'b1);
        send_at(ACT_TRIGGER, t0 + 100,   1'b0);
        send_at(ACT_SAMPLE,  t0 + 400,   1'b0);
        send_at(ACT_SAMPLE,  t0 + 800,   1'b1);
        send_at(ACT_SAMPLE,  t0 + 1200,  1'b0);
        send_at(ACT_SAMPLE,  t0 + 1300,  1'b1);
        send_at(ACT_TRIGGER, t0 + 1500,  1'b1);
        send_at(ACT_TRIGGER, t0 + 1600,  1'b0);
        send_at(ACT_SAMPLE,  t0 + 1700,  1'b0);
        send_at(ACT_SAMPLE,  t0 + 4000,  1'b0);
        send_at(ACT_SAMPLE,  t0 + 10000, 1'b1);
        send_at(ACT_SAMPLE,  t0 + 10500, 1'b0);
        send_at(ACT_SAMPLE,  t0 + 11000, 1'b1);
        send_at(ACT_TAKE,    t0 + 11100, 1'b0);
        send_at(ACT_TRIGGER, t0 + 12000, 1'b1);
        send_at(ACT_SAMPLE,  t0 + 14000, 1'b1);
        send_at(ACT_TRIGGER, t0 + 15000, 1'b0);
        send_at(ACT_SAMPLE,  t0 + 36000, 1'b1);
    endtask

    // Extreme settings: zero closing travel on reversal and a deadline beyond the report range.
    task automatic test_extreme_registers();
        logic [NOW_W-1:0] t1;
        wait_for_quiet();
        write_reg(REG_SETTLE,       32'd65535);
        write_reg(REG_OPEN_TRAVEL,  32'hFFFF_FFFF);
        write_reg(REG_CLOSE_TRAVEL, 32'hFFF0_0000);
        write_reg(REG_COOLDOWN,     32'd0);
        write_reg(REG_OPEN_IS_LOW,  32'd0);
        for (int k = REG_OPEN_IS_LOW + 1; k < (1 << REG_IDX_W); k++)
            write_reg(REG_IDX_W'(k), $urandom());
        t1 = 32'h7FFF_FF00;
        send_at(ACT_BOOT,    t1,          1'b1);
        send_at(ACT_SAMPLE,  t1 + 100,    1'b0);
        send_at(ACT_SAMPLE,  t1 + 200,    1'b1);
        send_at(ACT_SAMPLE,  t1 + 300,    1'b0);
        send_at(ACT_TRIGGER, t1 + 400,    1'b1);
        send_at(ACT_TAKE,    t1 - 599600, 1'b1);
        send_at(ACT_TRIGGER, t1 + 500,    1'b0);
    endtask

    task automatic test_random_sessions();
        logic [SETTLE_W-1:0] settle;
        logic [TRAVEL_W-1:0] open_t;
        logic [TRAVEL_W-1:0] close_t;
        logic [COOL_W-1:0]   cool;
        logic                low;
        int                  pick;
        int                  n;
        int                  stop_at;
        for (int k = 0; k < PHASE_COUNT; k++)
        begin
            wait_for_quiet();
            case (k)
                0:
                begin
                    settle = SETTLE_RST;
                    open_t = OPEN_TRAVEL_RST;
                    close_t = CLOSE_TRAVEL_RST;
                    cool = COOLDOWN_RST;
                    low = OPEN_IS_LOW_RST;
                end
                1:
                begin
                    settle = '0;
                    open_t = 20'd1;
                    close_t = 20'd1;
                    cool = '0;
                    low = 1'b0;
                end
                2:
                begin
                    settle = '1;
                    open_t = '1;
                    close_t = '1;
                    cool = '1;
                    low = 1'b1;
                end
                default:
                begin
                    settle = SETTLE_W'($urandom_range(0, 4000));
                    open_t = TRAVEL_W'($urandom_range(1, 60000));
                    close_t = ($urandom_range(0, 9) == 0) ? '0
                                                          : TRAVEL_W'($urandom_range(1, 60000));
                    cool = COOL_W'($urandom_range(0, 4000));
                    low = 1'($urandom_range(0, 1));
                end
            endcase
            // Upper data bits carry junk that the block must drop.
            write_reg(REG_SETTLE,       {16'($urandom()), settle});
            write_reg(REG_OPEN_TRAVEL,  {12'($urandom()), open_t});
            write_reg(REG_CLOSE_TRAVEL, {12'($urandom()), close_t});
            write_reg(REG_COOLDOWN,     {16'($urandom()), cool});
            write_reg(REG_OPEN_IS_LOW,  {31'($urandom()), low});
            clock_ms = $urandom();
            pin_now = 1'($urandom_range(0, 1));
            calm = (k == 3);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 3)
                    calm = !calm;
                if (pick < 35)
                begin
                    // A blinking line: flips close enough together to look like travel.
                    n = $urandom_range(2, 6);
                    repeat (n)
                    begin
                        pin_now = !pin_now;
                        clock_ms += $urandom_range(50, 1500);
                        send_request(ACT_SAMPLE, pin_now);
                    end
                end
                else if (pick < 55)
                begin
                    n = $urandom_range(0, 2);
                    repeat (n)
                    begin
                        clock_ms += $urandom_range(100, 1000);
                        send_request(ACT_SAMPLE, pin_now);
                    end
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = raw_flip_ms + cfg.settle_ms + $urandom_range(0, 2) - 1;
                    else
                        clock_ms += cfg.settle_ms + $urandom_range(0, 1000);
                    send_request(ACT_SAMPLE, pin_now);
                end
                else if (pick < 72)
                begin
                    n = $urandom_range(0, 3);
                    if (n == 0)
                        clock_ms = press_ms + cfg.cooldown_ms + $urandom_range(0, 2) - 1;
                    else if (n == 1)
                        clock_ms += $urandom_range(0, cfg.close_travel_ms + 3000);
                    else
                        clock_ms += $urandom_range(0, 1500);
                    send_request(ACT_TRIGGER, 1'($urandom_range(0, 1)));
                end
                else if (pick < 80)
                begin
                    clock_ms += $urandom_range(0, 500);
                    send_request(ACT_TAKE, 1'($urandom_range(0, 1)));
                end
                else if (pick < 84)
                begin
                    pin_now = 1'($urandom_range(0, 1));
                    clock_ms += $urandom_range(0, 500);
                    send_request(ACT_BOOT, pin_now);
                end
                else if (pick < 94)
                begin
                    // Quiet line while a deadline runs out, sometimes right on it.
                    if ($urandom_range(0, 2) == 0)
                        clock_ms = due_ms + $urandom_range(0, 2) - 1;
                    else
                        clock_ms += $urandom_range(0, 2 * cfg.open_travel_ms
                                                      + cfg.close_travel_ms);
                    send_request(ACT_SAMPLE, pin_now);
                end
                else
                begin
                    if ($urandom_range(0, 1))
                        clock_ms = $urandom();
                    else
                        clock_ms -= $urandom_range(0, 2000000);
                    send_request(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side: check each result against the oldest request, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result arrived with no request waiting for it");
                mismatches++;
            end
            else
            begin
                oldest = pending_reports.pop_front();
                compare_field("accepted", oldest.accepted, out_ch.accepted);
                compare_field("settled_open", oldest.settled_open, out_ch.settled_open);
                compare_field("partial", oldest.partial, out_ch.partial);
                compare_field("move_state", oldest.move_state, out_ch.move_state);
                compare_field("remaining_ms", oldest.remaining_ms, out_ch.remaining_ms);
                compare_field("external_event", oldest.external_event, out_ch.external_event);
                compare_field("since_trigger_ms", oldest.since_trigger_ms,
                              out_ch.since_trigger_ms);
            end
        end
        if (hold_left == 0)
        begin
            out_ch.ready <= 1'b1;
            hold_left = pause_len();
        end
        else
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ACT_SAMPLE;
        in_ch.now_ms    <= '0;
        in_ch.pin_level <= 1'b0;
        items_sent = 0;
        calm       = 1'b0;
        clock_ms   = '0;
        pin_now    = 1'b0;
        reset_tracker();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_extreme_registers();
        test_random_sessions();
        wait_for_quiet();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
